@@ src/integer_to_ascii_formatter_defines.svh @@
// Assertion macros shared by the formatter RTL.
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define I2AFMT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2AFMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/i2afmt_pkg.sv @@
// Types, constants and helper functions for the integer-to-ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none
package i2afmt_pkg;

   localparam int VALUE_W    = 32;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int HEX_DIGITS = 8;

   localparam logic [7:0] CHR_MINUS = 8'h2d;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_X     = 8'h78;
   localparam logic [7:0] CHR_ALPHA = 8'h57;

   typedef enum logic [1:0] {
      ACT_UDEC = 2'd0,
      ACT_SDEC = 2'd1,
      ACT_HEX  = 2'd2,
      ACT_PTR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PFX,
      ST_EMIT
   } state_type;

   function automatic logic [7:0] glyph(input logic [3:0] digit);
      logic [7:0] code;
      if (digit < 4'd10) begin
         code = CHR_ZERO + {4'h0, digit};
      end else begin
         code = CHR_ALPHA + {4'h0, digit};
      end
      return code;
   endfunction

   function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
      logic [BCD_W-1:0] res;
      res = bcd;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd[4*i +: 4] >= 4'd5) begin
            res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ src/i2afmt_if.sv @@
// Valid/ready channel interfaces for formatter requests and characters.
`timescale 1ns / 1ps
`default_nettype none
interface i2afmt_req_if import i2afmt_pkg::*; ();
   logic        valid;
   logic        ready;
   action_type  action;
   logic [31:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

interface i2afmt_rsp_if import i2afmt_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink (input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

@@ src/integer_to_ascii_formatter.sv @@
// Integer-to-ASCII formatter: decimal, signed decimal, hex and pointer text.
// Decimal: a double-dabble conversion of the 32-bit value, a minus sign for a negative
// signed value, then leading zero digits are skipped and the digits emitted.
// Hex: a 0x prefix for a pointer, then leading zero bytes are skipped and digits emitted.
// A request is taken only in idle; output stalls hold back each character.
// Synchronous reset returns the sequencer to idle and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"
module integer_to_ascii_formatter import i2afmt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   i2afmt_req_if.sink    req_ch,
   i2afmt_rsp_if.source  rsp_ch
);

   state_type              state_ff, state_in;
   action_type             mode_ff, mode_in;
   logic [VALUE_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]       work_ff, work_in;
   logic [4:0]             step_ff, step_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [1:0]             pfx_ff, pfx_in;
   logic                   started_ff, started_in;
   logic                   valid_ff, valid_in;
   logic [7:0]             char_ff, char_in;
   logic                   last_ff, last_in;

   logic                   slot_free;
   logic                   is_hex;
   logic [3:0]             digit;
   logic                   top_zero;
   logic                   skip;
   logic                   negative;
   logic [VALUE_W-1:0]     mag;
   logic [BCD_W-1:0]       adjusted;
   logic                   conv_last;
   logic                   rsp_stall;
   logic                   emitting;
   logic                   dec_emit;

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = valid_ff;
   assign rsp_ch.char_code = char_ff;
   assign rsp_ch.last_char = last_ff;

   assign slot_free = !valid_ff || rsp_ch.ready;
   assign is_hex    = (mode_ff == ACT_HEX) || (mode_ff == ACT_PTR);
   assign digit     = is_hex ? work_ff[31:28] : work_ff[BCD_W-1 -: 4];
   assign top_zero  = is_hex ? (work_ff[31:24] == 8'h00) : (work_ff[BCD_W-1 -: 4] == 4'h0);
   assign skip      = !started_ff && top_zero && (cnt_ff > (is_hex ? 4'd2 : 4'd1));
   assign negative  = (req_ch.action == ACT_SDEC) && req_ch.value[VALUE_W-1];
   assign mag       = negative ? (VALUE_W'(0) - req_ch.value) : req_ch.value;
   assign adjusted  = bcd_adjust(work_ff);

   assign conv_last = (state_ff == ST_CONV) && (step_ff == 5'(VALUE_W - 1));
   assign rsp_stall = valid_ff && !rsp_ch.ready;
   assign emitting  = (state_ff == ST_EMIT);
   assign dec_emit  = emitting && !is_hex;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      bin_in     = bin_ff;
      work_in    = work_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      pfx_in     = pfx_ff;
      started_in = started_ff;
      valid_in   = valid_ff && !rsp_ch.ready;
      char_in    = char_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mode_in    = req_ch.action;
               bin_in     = mag;
               step_in    = 5'd0;
               started_in = 1'b0;
               if (req_ch.action == ACT_PTR) begin
                  pfx_in = 2'd2;
               end else if (negative) begin
                  pfx_in = 2'd1;
               end else begin
                  pfx_in = 2'd0;
               end
               if ((req_ch.action == ACT_HEX) || (req_ch.action == ACT_PTR)) begin
                  work_in  = {(BCD_W - VALUE_W)'(0), req_ch.value};
                  cnt_in   = 4'(HEX_DIGITS);
                  state_in = ST_PFX;
               end else begin
                  work_in  = '0;
                  cnt_in   = 4'(BCD_DIGITS);
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            work_in = {adjusted[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in  = {bin_ff[VALUE_W-2:0], 1'b0};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(VALUE_W - 1)) begin
               state_in = ST_PFX;
            end
         end
         ST_PFX: begin
            if (pfx_ff == 2'd0) begin
               state_in = ST_EMIT;
            end else if (slot_free) begin
               valid_in = 1'b1;
               last_in  = 1'b0;
               pfx_in   = pfx_ff - 2'd1;
               if (pfx_ff == 2'd2) begin
                  char_in = CHR_ZERO;
               end else if (mode_ff == ACT_PTR) begin
                  char_in = CHR_X;
               end else begin
                  char_in = CHR_MINUS;
               end
            end
         end
         ST_EMIT: begin
            if (skip) begin
               if (is_hex) begin
                  work_in = {work_ff[BCD_W-9:0], 8'h00};
                  cnt_in  = cnt_ff - 4'd2;
               end else begin
                  work_in = {work_ff[BCD_W-5:0], 4'h0};
                  cnt_in  = cnt_ff - 4'd1;
               end
            end else if (slot_free) begin
               valid_in   = 1'b1;
               char_in    = glyph(digit);
               last_in    = (cnt_ff == 4'd1);
               work_in    = {work_ff[BCD_W-5:0], 4'h0};
               cnt_in     = cnt_ff - 4'd1;
               started_in = 1'b1;
               if (cnt_ff == 4'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      bin_ff     <= bin_in;
      work_ff    <= work_in;
      step_ff    <= step_in;
      cnt_ff     <= cnt_in;
      pfx_ff     <= pfx_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   `I2AFMT_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, valid_ff && $stable(char_ff), "beat lost")
   `I2AFMT_ASSERT_NEXT(a_conv_done, clock, reset, conv_last, state_ff == ST_PFX, "late conversion")
   `I2AFMT_ASSERT_NOW(a_emit_count, clock, reset, emitting, cnt_ff != 4'd0, "digit count empty")
   `I2AFMT_ASSERT_NOW(a_bcd_digit, clock, reset, dec_emit, digit <= 4'd9, "bad decimal digit")

endmodule
`default_nettype wire
